@@ design/tfe_pkg.sv @@
// shared package of the tricolor framebuffer engine
// request, colour and rotation codes, default panel size and the plane word type
// no dependencies
package tfe_pkg;

  localparam int DEF_PANEL_WIDTH  = 400;
  localparam int DEF_PANEL_HEIGHT = 300;

  localparam logic [1:0] REQ_DRAW = 2'd0;
  localparam logic [1:0] REQ_FILL = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_BLACK = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic PLANE_BLACK = 1'b0;
  localparam logic PLANE_RED   = 1'b1;

  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [7:0] INK_BYTE   = 8'h00;

  // one byte of each plane at the same byte index
  typedef struct packed {
    logic [7:0] black;
    logic [7:0] red;
  } plane_word_t;

endpackage

@@ design/tfe_addr.sv @@
// pixel address unit: bounds check, rotation and byte index of a draw request
// registers the panel coordinates at the request transfer, then forms index and bit mask
// depends on tfe_pkg
module tfe_addr #(
  parameter int PANEL_WIDTH  = tfe_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = tfe_pkg::DEF_PANEL_HEIGHT,
  localparam int RowBytes    = (PANEL_WIDTH + 7) / 8,
  localparam int PlaneBytes  = RowBytes * PANEL_HEIGHT,
  localparam int AW          = (PlaneBytes > 1) ? $clog2(PlaneBytes) : 1
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [1:0]           rotation_i,
  input  logic signed [10:0]   pos_x_i,
  input  logic signed [10:0]   pos_y_i,
  output logic                 drop_o,
  output logic [AW-1:0]        index_o,
  output logic [7:0]           mask_o
);

  localparam int XW = $clog2(PANEL_WIDTH);
  localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam logic [10:0] W11 = 11'(PANEL_WIDTH);
  localparam logic [10:0] H11 = 11'(PANEL_HEIGHT);

  logic [10:0]   xu, yu, w_lim, h_lim, px11, py11;
  logic          drop_d;
  logic [XW-1:0] px_q;
  logic [YW-1:0] py_q;
  logic          drop_q;

  always_comb begin
    xu    = {1'b0, pos_x_i[9:0]};
    yu    = {1'b0, pos_y_i[9:0]};
    w_lim = rotation_i[0] ? H11 : W11;
    h_lim = rotation_i[0] ? W11 : H11;
    drop_d = pos_x_i[10] || pos_y_i[10] || (xu >= w_lim) || (yu >= h_lim);
    case (rotation_i)
      tfe_pkg::ROT_90: begin
        px11 = W11 - 11'd1 - yu;
        py11 = xu;
      end
      tfe_pkg::ROT_180: begin
        px11 = W11 - 11'd1 - xu;
        py11 = H11 - 11'd1 - yu;
      end
      tfe_pkg::ROT_270: begin
        px11 = yu;
        py11 = H11 - 11'd1 - xu;
      end
      default: begin
        px11 = xu;
        py11 = yu;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      px_q   <= px11[XW-1:0];
      py_q   <= py11[YW-1:0];
      drop_q <= drop_d;
    end
  end

  assign drop_o  = drop_q;
  assign index_o = AW'(AW'(py_q) * AW'(RowBytes)) + AW'(px_q >> 3);
  assign mask_o  = 8'h80 >> px_q[2:0];

endmodule

@@ design/tfe_plane_mem.sv @@
// plane store: one synchronous memory holding a black byte and a red byte per word
// single port, registered read data, no reset of contents
// depends on tfe_pkg
module tfe_plane_mem #(
  parameter int DEPTH = ((tfe_pkg::DEF_PANEL_WIDTH + 7) / 8) * tfe_pkg::DEF_PANEL_HEIGHT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         addr_i,
  input  tfe_pkg::plane_word_t  wdata_i,
  output tfe_pkg::plane_word_t  rdata_o
);

  tfe_pkg::plane_word_t mem [DEPTH];
  tfe_pkg::plane_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tricolor_framebuffer_engine.sv @@
// top level of the tricolor framebuffer engine: request sequencer and rotation register
// instantiates tfe_addr and tfe_plane_mem, depends on tfe_pkg
//
// Requests are taken one at a time: a request transfers when start is high and busy is low.
// Draw, read and unknown requests keep busy high through an address state and a modify
// state (read of one plane word and, for a draw on the panel, its write back), and the
// result strobe result_valid_o comes once the block is idle again. A fill writes one
// word per cycle over the whole store, RowBytes * PANEL_HEIGHT words (15000 at the
// default size), with the strobe right after the last write. After reset the block
// whitens the whole store with busy high. The strobe lasts one cycle and cannot be
// held off. The rotation register may be written at any time the block is idle and
// applies from the next request on.
module tricolor_framebuffer_engine #(
  parameter int PANEL_WIDTH  = tfe_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = tfe_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic signed [10:0]  pos_x_i,
  input  logic signed [10:0]  pos_y_i,
  input  logic [1:0]          colour_code_i,
  input  logic                plane_select_i,
  input  logic [13:0]         byte_index_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  output logic                result_valid_o,
  output logic [7:0]          read_byte_o,
  output logic                pixel_dropped_o
);

  localparam int RowBytes   = (PANEL_WIDTH + 7) / 8;
  localparam int PlaneBytes = RowBytes * PANEL_HEIGHT;
  localparam int AW         = (PlaneBytes > 1) ? $clog2(PlaneBytes) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MOD,
    ST_FILL
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic [1:0]    rot_q;
  logic [1:0]    req_q;
  logic [1:0]    colour_q;
  logic          plane_q;
  logic [13:0]   bidx_q;
  logic          done_q;
  logic [7:0]    rbyte_q;
  logic          drop_q;

  logic                 load;
  logic                 pix_drop;
  logic [AW-1:0]        pix_index;
  logic [7:0]           pix_mask;
  logic                 cnt_last;
  logic                 in_range;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  tfe_pkg::plane_word_t mem_wdata;
  tfe_pkg::plane_word_t mem_rdata;
  logic [7:0]           sel_byte;

  assign busy     = (state_q != ST_IDLE);
  assign load     = start && (state_q == ST_IDLE);
  assign cnt_last = (cnt_q == AW'(PlaneBytes - 1));
  assign in_range = (32'(bidx_q) < 32'(PlaneBytes));
  assign sel_byte = (plane_q == tfe_pkg::PLANE_RED) ? mem_rdata.red : mem_rdata.black;

  tfe_addr #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_addr (
    .clk_i      (clk_i),
    .load_i     (load),
    .rotation_i (rot_q),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .drop_o     (pix_drop),
    .index_o    (pix_index),
    .mask_o     (pix_mask)
  );

  tfe_plane_mem #(
    .DEPTH (PlaneBytes)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cnt_q;
    mem_wdata = '{black: tfe_pkg::WHITE_BYTE, red: tfe_pkg::WHITE_BYTE};
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wdata.black = (colour_q == tfe_pkg::COL_BLACK) ? tfe_pkg::INK_BYTE
                                                           : tfe_pkg::WHITE_BYTE;
        mem_wdata.red   = (colour_q == tfe_pkg::COL_RED) ? tfe_pkg::INK_BYTE
                                                         : tfe_pkg::WHITE_BYTE;
      end
      ST_ADDR: begin
        mem_addr = (req_q == tfe_pkg::REQ_DRAW) ? pix_index : AW'(bidx_q);
      end
      ST_MOD: begin
        // set the pixel white in both planes, then ink the chosen one
        mem_addr = pix_index;
        mem_we   = (req_q == tfe_pkg::REQ_DRAW) && !pix_drop;
        mem_wdata.black = (colour_q == tfe_pkg::COL_BLACK) ? (mem_rdata.black & ~pix_mask)
                                                           : (mem_rdata.black | pix_mask);
        mem_wdata.red   = (colour_q == tfe_pkg::COL_RED) ? (mem_rdata.red & ~pix_mask)
                                                         : (mem_rdata.red | pix_mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      rot_q    <= tfe_pkg::ROT_0;
      req_q    <= tfe_pkg::REQ_DRAW;
      colour_q <= tfe_pkg::COL_WHITE;
      plane_q  <= tfe_pkg::PLANE_BLACK;
      bidx_q   <= '0;
      done_q   <= 1'b0;
      rbyte_q  <= '0;
      drop_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        rot_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_CLEAR: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q    <= req_type_i;
            colour_q <= colour_code_i;
            plane_q  <= plane_select_i;
            bidx_q   <= byte_index_i;
            cnt_q    <= '0;
            state_q  <= (req_type_i == tfe_pkg::REQ_FILL) ? ST_FILL : ST_ADDR;
          end
        end
        ST_ADDR: begin
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          done_q  <= 1'b1;
          drop_q  <= (req_q == tfe_pkg::REQ_DRAW) && pix_drop;
          if (req_q == tfe_pkg::REQ_READ) begin
            rbyte_q <= in_range ? sel_byte : tfe_pkg::WHITE_BYTE;
          end else begin
            rbyte_q <= '0;
          end
          state_q <= ST_IDLE;
        end
        ST_FILL: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            rbyte_q <= '0;
            drop_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o  = done_q;
  assign read_byte_o     = rbyte_q;
  assign pixel_dropped_o = drop_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while a request is still at work");

  a_short_req_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i != tfe_pkg::REQ_FILL)) |-> ##3 result_valid_o)
    else $error("short request did not answer in the third cycle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_FILL) || (state_q == ST_MOD)))
    else $error("plane write outside clear, fill or modify");

endmodule

@@ tb/sv/tb_tricolor_framebuffer_engine.sv @@
// testbench of the tricolor framebuffer engine: directed and random draw, fill, read
// and unknown requests over all rotations, checked on a byte-level model of both planes
// depends on tfe_pkg and tricolor_framebuffer_engine
module tb_tricolor_framebuffer_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W     = tfe_pkg::DEF_PANEL_WIDTH;
  localparam int PANEL_H     = tfe_pkg::DEF_PANEL_HEIGHT;
  localparam int ROW_BYTES   = (PANEL_W + 7) / 8;
  localparam int PLANE_BYTES = ROW_BYTES * PANEL_H;

  localparam logic [1:0] REQ_DRAW    = tfe_pkg::REQ_DRAW;
  localparam logic [1:0] REQ_FILL    = tfe_pkg::REQ_FILL;
  localparam logic [1:0] REQ_READ    = tfe_pkg::REQ_READ;
  localparam logic [1:0] COL_WHITE   = tfe_pkg::COL_WHITE;
  localparam logic [1:0] COL_BLACK   = tfe_pkg::COL_BLACK;
  localparam logic [1:0] COL_RED     = tfe_pkg::COL_RED;
  localparam logic [1:0] ROT_0       = tfe_pkg::ROT_0;
  localparam logic [1:0] ROT_90      = tfe_pkg::ROT_90;
  localparam logic [1:0] ROT_180     = tfe_pkg::ROT_180;
  localparam logic [1:0] ROT_270     = tfe_pkg::ROT_270;
  localparam logic       PLANE_BLACK = tfe_pkg::PLANE_BLACK;
  localparam logic       PLANE_RED   = tfe_pkg::PLANE_RED;
  localparam logic [7:0] WHITE_BYTE  = tfe_pkg::WHITE_BYTE;
  localparam logic [7:0] INK_BYTE    = tfe_pkg::INK_BYTE;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] COL_OTHER   = 2'd3;

  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 8;
  localparam int MAX_FILLS    = 8;

  typedef struct {
    logic [1:0]         req;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [1:0]         colour;
    logic               plane;
    logic [13:0]        bidx;
  } fb_req_t;

  typedef struct {
    logic [7:0] rd;
    logic       dropped;
  } fb_result_t;

  class plane_scoreboard;
    logic [7:0] black_bytes [PLANE_BYTES];
    logic [7:0] red_bytes [PLANE_BYTES];
    logic [1:0] rot;
    fb_result_t expected_results[$];
    int errors, checked, last_idx;
    int n_draw, n_drop, n_fill, n_read, n_unknown;

    function new();
      rot = ROT_0;
      last_idx = 0;
      for (int i = 0; i < PLANE_BYTES; i++) begin
        black_bytes[14'(i)] = WHITE_BYTE;
        red_bytes[14'(i)] = WHITE_BYTE;
      end
    endfunction

    function void set_rotation(logic [1:0] r);
      rot = r;
    endfunction

    function void note_request(fb_req_t r);
      fb_result_t e;
      int w, h, x, y, px, py, idx;
      logic [13:0] ai;
      logic [7:0] mask, fb, fr;
      e.rd = 8'h00;
      e.dropped = 1'b0;
      case (r.req)
        REQ_DRAW: begin
          n_draw++;
          w = rot[0] ? PANEL_H : PANEL_W;
          h = rot[0] ? PANEL_W : PANEL_H;
          x = int'(r.pos_x);
          y = int'(r.pos_y);
          if (x < 0 || x >= w || y < 0 || y >= h) begin
            e.dropped = 1'b1;
          end else begin
            case (rot)
              ROT_90: begin
                px = PANEL_W - 1 - y;
                py = x;
              end
              ROT_180: begin
                px = PANEL_W - 1 - x;
                py = PANEL_H - 1 - y;
              end
              ROT_270: begin
                px = y;
                py = PANEL_H - 1 - x;
              end
              default: begin
                px = x;
                py = y;
              end
            endcase
            idx = py * ROW_BYTES + px / 8;
            if (idx >= PLANE_BYTES) begin
              e.dropped = 1'b1;
            end else begin
              last_idx = idx;
              ai = 14'(idx);
              mask = 8'h80 >> (px % 8);
              black_bytes[ai] = black_bytes[ai] | mask;
              red_bytes[ai] = red_bytes[ai] | mask;
              if (r.colour == COL_BLACK) begin
                black_bytes[ai] = black_bytes[ai] & ~mask;
              end else if (r.colour == COL_RED) begin
                red_bytes[ai] = red_bytes[ai] & ~mask;
              end
            end
          end
          if (e.dropped) n_drop++;
        end
        REQ_FILL: begin
          n_fill++;
          fb = (r.colour == COL_BLACK) ? INK_BYTE : WHITE_BYTE;
          fr = (r.colour == COL_RED) ? INK_BYTE : WHITE_BYTE;
          for (int i = 0; i < PLANE_BYTES; i++) begin
            black_bytes[14'(i)] = fb;
            red_bytes[14'(i)] = fr;
          end
        end
        REQ_READ: begin
          n_read++;
          if (r.bidx < PLANE_BYTES) begin
            e.rd = (r.plane == PLANE_RED) ? red_bytes[r.bidx] : black_bytes[r.bidx];
          end else begin
            e.rd = WHITE_BYTE;
          end
        end
        default: begin
          n_unknown++;
        end
      endcase
      expected_results.push_back(e);
    endfunction

    function void check_result(logic [7:0] rd, logic dropped);
      fb_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, read_byte %02h pixel_dropped %0b",
                 $time, rd, dropped);
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (rd !== e.rd) begin
        errors++;
        $display("%0t: read_byte expected %02h actual %02h", $time, e.rd, rd);
      end
      if (dropped !== e.dropped) begin
        errors++;
        $display("%0t: pixel_dropped expected %0b actual %0b", $time, e.dropped, dropped);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_UNKNOWN;
  logic signed [10:0] pos_x = '0;
  logic signed [10:0] pos_y = '0;
  logic [1:0]         colour_code = COL_WHITE;
  logic               plane_select = PLANE_BLACK;
  logic [13:0]        byte_index = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_wdata = ROT_0;
  logic               result_valid;
  logic [7:0]         read_byte;
  logic               pixel_dropped;

  plane_scoreboard sb = new();
  int fills_left = MAX_FILLS;

  tricolor_framebuffer_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .colour_code_i   (colour_code),
    .plane_select_i  (plane_select),
    .byte_index_i    (byte_index),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .result_valid_o  (result_valid),
    .read_byte_o     (read_byte),
    .pixel_dropped_o (pixel_dropped)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid) sb.check_result(read_byte, pixel_dropped);
  end

  function automatic fb_req_t mk_req(logic [1:0] req, int x, int y, logic [1:0] colour,
                                     logic plane, int idx);
    fb_req_t r;
    r.req = req;
    r.pos_x = 11'(x);
    r.pos_y = 11'(y);
    r.colour = colour;
    r.plane = plane;
    r.bidx = 14'(idx);
    return r;
  endfunction

  function automatic int edge_coord(int limit);
    case ($urandom_range(0, 3))
      0: return -1;
      1: return 0;
      2: return limit - 1;
      default: return limit;
    endcase
  endfunction

  function automatic fb_req_t random_request(logic [1:0] rot);
    fb_req_t r;
    int w, h, sel, idx;
    w = rot[0] ? PANEL_H : PANEL_W;
    h = rot[0] ? PANEL_W : PANEL_H;
    r = mk_req(REQ_DRAW, int'($urandom), int'($urandom), 2'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), int'($urandom_range(0, 16383)));
    sel = int'($urandom_range(0, 999));
    if (sel < 520) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          r.pos_x = 11'(edge_coord(w));
          r.pos_y = 11'(edge_coord(h));
        end
        3, 4: ;
        default: begin
          r.pos_x = 11'($urandom_range(0, w - 1));
          r.pos_y = 11'($urandom_range(0, h - 1));
        end
      endcase
    end else if (sel < 960) begin
      r.req = REQ_READ;
      case ($urandom_range(0, 19))
        0, 1, 2: ;
        3, 4, 5: r.bidx = 14'($urandom_range(PLANE_BYTES - 8, PLANE_BYTES + 8));
        6, 7, 8: r.bidx = 14'($urandom_range(0, PLANE_BYTES - 1));
        default: begin
          idx = sb.last_idx + int'($urandom_range(0, 2)) - 1;
          r.bidx = (idx < 0) ? 14'd0 : 14'(idx);
        end
      endcase
    end else if (sel < 966 && fills_left > 0) begin
      r.req = REQ_FILL;
      fills_left--;
    end else begin
      r.req = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // called in a rising-edge step; returns in the step of the transfer edge
  task automatic send_request(fb_req_t r);
    start <= 1'b1;
    req_type <= r.req;
    pos_x <= r.pos_x;
    pos_y <= r.pos_y;
    colour_code <= r.colour;
    plane_select <= r.plane;
    byte_index <= r.bidx;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_rotation(logic [1:0] r);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_rotation(r);
  endtask

  task automatic run_random(int count, logic [1:0] rot);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = int'($urandom_range(1, 24));
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_request(rot));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    fb_req_t directed[$];
    logic [1:0] rot;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wait_drained();
    write_rotation(ROT_0);

    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, PLANE_BYTES - 1));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_BLACK, PLANE_BYTES));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, 16383));
    directed.push_back(mk_req(REQ_DRAW, 0, 0, COL_BLACK, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, PANEL_W - 1, PANEL_H - 1, COL_RED, PLANE_RED, 0));
    directed.push_back(mk_req(REQ_DRAW, 7, 0, COL_RED, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, 1, 0, COL_OTHER, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, -1, 0, COL_BLACK, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, PANEL_W, 0, COL_BLACK, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, 0, PANEL_H, COL_RED, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, -1024, -1024, COL_BLACK, PLANE_RED, 0));
    directed.push_back(mk_req(REQ_DRAW, 1023, 1023, COL_RED, PLANE_RED, 16383));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, PLANE_BYTES - 1));
    directed.push_back(mk_req(REQ_UNKNOWN, 1023, -1024, COL_OTHER, PLANE_RED, 16383));
    directed.push_back(mk_req(REQ_FILL, 0, 0, COL_BLACK, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_BLACK, 77));
    directed.push_back(mk_req(REQ_FILL, 0, 0, COL_RED, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, 14000));
    directed.push_back(mk_req(REQ_FILL, 0, 0, COL_OTHER, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_DRAW, 5, 3, COL_RED, PLANE_BLACK, 0));
    directed.push_back(mk_req(REQ_READ, 0, 0, COL_WHITE, PLANE_RED, 3 * ROW_BYTES));
    directed.push_back(mk_req(REQ_FILL, 0, 0, COL_WHITE, PLANE_BLACK, 0));
    foreach (directed[i]) send_request(directed[i]);
    start <= 1'b0;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: rot = ROT_90;
        1: rot = ROT_180;
        2: rot = ROT_270;
        3: rot = ROT_0;
        default: rot = 2'($urandom_range(0, 3));
      endcase
      write_rotation(rot);
      run_random(RANDOM_ITEMS / PHASES, rot);
      @(posedge clk_i);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d results: %0d draws (%0d off panel), %0d fills, %0d reads, %0d unknown",
             sb.checked, sb.n_draw, sb.n_drop, sb.n_fill, sb.n_read, sb.n_unknown);
    $display("all four rotations exercised with random sender bursts and gaps");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
